### hdl/rhsv_pkg.sv
// Package: shared widths, constants and the pipeline payload type for the RGB-to-HSV unit.
`timescale 1ns / 1ps
`default_nettype none
package rhsv_pkg;

  // Channel and field widths
  localparam int unsigned CW = 8;   // color channel
  localparam int unsigned HW = 9;   // hue field

  // Divider chain: one quotient bit per cell
  localparam int unsigned QW = 9;   // quotient bits, also number of cells
  localparam int unsigned DW = 9;   // divisor width (2*delta or 2*max)
  localparam int unsigned RW = 18;  // dividend / partial remainder width

  // Hue wraps at a full turn
  localparam logic [HW-1:0] HUE_TURN = HW'(360);

  // Payload carried through every stage of the chain
  typedef struct packed {
    logic [RW-1:0] rem_h;   // hue partial remainder
    logic [DW-1:0] div_h;   // hue divisor
    logic [QW-1:0] q_h;     // hue quotient bits so far
    logic [RW-1:0] rem_s;   // saturation partial remainder
    logic [DW-1:0] div_s;   // saturation divisor
    logic [QW-1:0] q_s;     // saturation quotient bits so far
    logic [CW-1:0] bright;  // max channel
    logic [CW-1:0] alpha;   // pass-through alpha
  } rhsv_pl_t;

endpackage : rhsv_pkg
`default_nettype wire

### hdl/rgb_to_hsv_unit.sv
// Top level: RGB pixel to HSV pixel, front stage, divider cell chain and output register.
//
//   channel | ports                                        | direction
//   --------+----------------------------------------------+----------
//   input   | in_valid, in_stall, in_red/green/blue/alpha_in | pixel in
//   result  | out_valid, out_stall, out_hue/saturation/...  | HSV out
//
// One transaction per clock sustained while out_stall is low; a pixel passes
// through the front stage, nine divider cells and the output register. The
// chain of nine cells, one quotient bit each, makes up most of the latency.
// Synchronous active-low reset empties every stage; payload is not reset.
// Each stage holds while stalled and accepts when empty or moving, so bubbles
// collapse and in_stall rises only when the whole chain is full.
`timescale 1ns / 1ps
`default_nettype none
module rgb_to_hsv_unit (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [rhsv_pkg::CW-1:0] in_red,
  input  wire logic [rhsv_pkg::CW-1:0] in_green,
  input  wire logic [rhsv_pkg::CW-1:0] in_blue,
  input  wire logic [rhsv_pkg::CW-1:0] in_alpha_in,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [rhsv_pkg::HW-1:0]      out_hue,
  output logic [rhsv_pkg::CW-1:0]      out_saturation,
  output logic [rhsv_pkg::CW-1:0]      out_brightness,
  output logic [rhsv_pkg::CW-1:0]      out_alpha_out
);
  import rhsv_pkg::*;

  logic     v   [QW+1];
  logic     stl [QW+1];
  rhsv_pl_t pl  [QW+1];

  logic [HW-1:0] hue_nxt;
  logic          ready;
  logic          v_r;
  logic [HW-1:0] hue_r;
  logic [CW-1:0] sat_r, bright_r, alpha_r;

  // Front stage
  rhsv_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .red      (in_red),
    .green    (in_green),
    .blue     (in_blue),
    .alpha    (in_alpha_in),
    .dn_valid (v[0]),
    .dn_stall (stl[0]),
    .dn_pl    (pl[0])
  );

  // Divider chain, most significant quotient bit first
  for (genvar i = 0; i < QW; i++) begin : g_cell
    rhsv_div_cell #(
      .BIT (QW - 1 - i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (v[i]),
      .up_stall (stl[i]),
      .up_pl    (pl[i]),
      .dn_valid (v[i+1]),
      .dn_stall (stl[i+1]),
      .dn_pl    (pl[i+1])
    );
  end

  // Hue of a full turn wraps to zero
  assign hue_nxt = (pl[QW].q_h >= HUE_TURN) ? (pl[QW].q_h - HUE_TURN) : pl[QW].q_h;

  // Output register
  assign ready   = !v_r || !out_stall;
  assign stl[QW] = !ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready) begin
      v_r <= v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (ready && v[QW]) begin
      hue_r    <= hue_nxt;
      sat_r    <= pl[QW].q_s[CW-1:0];
      bright_r <= pl[QW].bright;
      alpha_r  <= pl[QW].alpha;
    end
  end

  assign out_valid      = v_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_brightness = bright_r;
  assign out_alpha_out  = alpha_r;

  // Hue always in range after the wrap
  a_hue_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hue < HUE_TURN))
    else $error("hue out of range");

  // Black pixel gives zero hue and saturation
  a_black : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_brightness == '0)) |-> ((out_hue == '0) && (out_saturation == '0)))
    else $error("black pixel with nonzero hue or saturation");

  // Saturation quotient never needs its top bit
  a_sat_msb : assert property (@(posedge clk) disable iff (!rst_n)
    v[QW] |-> !pl[QW].q_s[QW-1])
    else $error("saturation quotient overflow");

  // Empty right after reset
  a_reset_empty : assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule : rgb_to_hsv_unit
`default_nettype wire

### hdl/rhsv_prep.sv
// Front stage: max/min, hue sector numerator and saturation dividend, registered.
`timescale 1ns / 1ps
`default_nettype none
module rhsv_prep (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  up_valid,
  output logic                       up_stall,
  input  wire logic [rhsv_pkg::CW-1:0] red,
  input  wire logic [rhsv_pkg::CW-1:0] green,
  input  wire logic [rhsv_pkg::CW-1:0] blue,
  input  wire logic [rhsv_pkg::CW-1:0] alpha,
  output logic                       dn_valid,
  input  wire logic                  dn_stall,
  output rhsv_pkg::rhsv_pl_t         dn_pl
);
  import rhsv_pkg::*;

  logic [CW-1:0]      mx, mn, dlt;
  logic               r_max, g_max;
  logic signed [19:0] rs, gs, bs, ds;
  logic signed [19:0] n_raw, n_pos, n_dbl;
  logic [RW-1:0]      num_s;
  logic               ready;
  rhsv_pl_t           pl_nxt;
  logic               v_r;
  rhsv_pl_t           pl_r;

  // Max / min with red over green over blue on ties
  always_comb begin
    r_max = (red >= green) && (red >= blue);
    g_max = !r_max && (green >= blue);
    mx    = r_max ? red : (g_max ? green : blue);
    if ((red <= green) && (red <= blue)) begin
      mn = red;
    end else if (green <= blue) begin
      mn = green;
    end else begin
      mn = blue;
    end
    dlt = mx - mn;
  end

  // Hue numerator: 2*N + delta, N folded into [0, 360*delta)
  always_comb begin
    rs = $signed({12'd0, red});
    gs = $signed({12'd0, green});
    bs = $signed({12'd0, blue});
    ds = $signed({12'd0, dlt});
    if (r_max) begin
      n_raw = 20'sd60 * (gs - bs);
    end else if (g_max) begin
      n_raw = 20'sd120 * ds + 20'sd60 * (bs - rs);
    end else begin
      n_raw = 20'sd240 * ds + 20'sd60 * (rs - gs);
    end
    n_pos = (n_raw < 20'sd0) ? (n_raw + 20'sd360 * ds) : n_raw;
    n_dbl = (n_pos <<< 1) + ds;
  end

  // Saturation dividend: 510*delta + max
  assign num_s = RW'({10'd0, dlt} * 18'd510) + RW'({10'd0, mx});

  // Stage payload; zero divisors replaced so the chain yields zero
  always_comb begin
    pl_nxt        = '0;
    pl_nxt.bright = mx;
    pl_nxt.alpha  = alpha;
    if (dlt == '0) begin
      pl_nxt.rem_h = '0;
      pl_nxt.div_h = DW'(1);
    end else begin
      pl_nxt.rem_h = n_dbl[RW-1:0];
      pl_nxt.div_h = {dlt, 1'b0};
    end
    if (mx == '0) begin
      pl_nxt.rem_s = '0;
      pl_nxt.div_s = DW'(1);
    end else begin
      pl_nxt.rem_s = num_s;
      pl_nxt.div_s = {mx, 1'b0};
    end
  end

  // Stage register with pass-through ready
  assign ready    = !v_r || !dn_stall;
  assign up_stall = !ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && up_valid) begin
      pl_r <= pl_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_pl    = pl_r;

endmodule : rhsv_prep
`default_nettype wire

### hdl/rhsv_div_cell.sv
// Divider cell: resolves one quotient bit of both the hue and saturation divisions.
`timescale 1ns / 1ps
`default_nettype none
module rhsv_div_cell #(
  parameter int unsigned BIT = 0
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               up_valid,
  output logic                    up_stall,
  input  wire rhsv_pkg::rhsv_pl_t up_pl,
  output logic                    dn_valid,
  input  wire logic               dn_stall,
  output rhsv_pkg::rhsv_pl_t      dn_pl
);
  import rhsv_pkg::*;

  logic [RW-1:0] sh_h, sh_s;
  logic          ge_h, ge_s;
  logic          ready;
  rhsv_pl_t      pl_nxt;
  logic          v_r;
  rhsv_pl_t      pl_r;

  // Restoring step: compare remainder against divisor shifted to this bit
  always_comb begin
    sh_h   = RW'(up_pl.div_h) << BIT;
    sh_s   = RW'(up_pl.div_s) << BIT;
    ge_h   = up_pl.rem_h >= sh_h;
    ge_s   = up_pl.rem_s >= sh_s;
    pl_nxt = up_pl;
    if (ge_h) begin
      pl_nxt.rem_h = up_pl.rem_h - sh_h;
    end
    if (ge_s) begin
      pl_nxt.rem_s = up_pl.rem_s - sh_s;
    end
    pl_nxt.q_h[BIT] = ge_h;
    pl_nxt.q_s[BIT] = ge_s;
  end

  // Stage register
  assign ready    = !v_r || !dn_stall;
  assign up_stall = !ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && up_valid) begin
      pl_r <= pl_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_pl    = pl_r;

endmodule : rhsv_div_cell
`default_nettype wire

### tb/sv/hsv_conv_checker.sv
// Checker for the RGB-to-HSV unit: watches both channels, predicts each pixel, compares results.
`timescale 1ns / 1ps
module hsv_conv_checker
  import rhsv_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  logic [CW-1:0] in_red,
  input  logic [CW-1:0] in_green,
  input  logic [CW-1:0] in_blue,
  input  logic [CW-1:0] in_alpha_in,
  input  logic          out_valid,
  input  logic          out_stall,
  input  logic [HW-1:0] out_hue,
  input  logic [CW-1:0] out_saturation,
  input  logic [CW-1:0] out_brightness,
  input  logic [CW-1:0] out_alpha_out,
  output int            fail_count,
  output int            pending_px
);

  typedef struct packed {
    logic [HW-1:0] hue;
    logic [CW-1:0] saturation;
    logic [CW-1:0] brightness;
    logic [CW-1:0] alpha;
  } hsv_px_t;

  // HSV pixels still owed by the unit, oldest first
  hsv_px_t expected_px[$];

  initial begin
    fail_count = 0;
    pending_px = 0;
  end

  // Exact integer HSV conversion; equal maxima pick red, then green
  function automatic hsv_px_t convert_pixel(logic [CW-1:0] r, logic [CW-1:0] g,
                                            logic [CW-1:0] b, logic [CW-1:0] a);
    int ri, gi, bi, top_ch, low_ch, spread, num, deg;
    hsv_px_t px;
    ri = r;
    gi = g;
    bi = b;
    top_ch = (ri > gi) ? ri : gi;
    top_ch = (top_ch > bi) ? top_ch : bi;
    low_ch = (ri < gi) ? ri : gi;
    low_ch = (low_ch < bi) ? low_ch : bi;
    spread = top_ch - low_ch;
    px.hue = '0;
    px.saturation = '0;
    px.brightness = CW'(top_ch);
    px.alpha = a;
    // black leaves saturation at zero
    if (top_ch != 0) begin
      px.saturation = CW'((2 * 255 * spread + top_ch) / (2 * top_ch));
    end
    // grey and black leave hue at zero
    if (spread != 0) begin
      if (ri == top_ch) begin
        num = 60 * (gi - bi);
      end else if (gi == top_ch) begin
        num = 120 * spread + 60 * (bi - ri);
      end else begin
        num = 240 * spread + 60 * (ri - gi);
      end
      if (num < 0) begin
        num += 360 * spread;
      end
      deg = (2 * num + spread) / (2 * spread);
      // rounding up to a full turn wraps to zero
      if (deg >= 360) begin
        deg -= 360;
      end
      px.hue = HW'(deg);
    end
    return px;
  endfunction

  function automatic void check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      fail_count++;
    end
  endfunction

  // Queue predictions on input transactions, compare on result transactions
  always @(posedge clk) begin
    hsv_px_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_px.push_back(convert_pixel(in_red, in_green, in_blue, in_alpha_in));
      end
      if (out_valid && !out_stall) begin
        if (expected_px.size() == 0) begin
          $error("unexpected result transaction: hue %0d sat %0d val %0d alpha %0d",
                 out_hue, out_saturation, out_brightness, out_alpha_out);
          fail_count++;
        end else begin
          want = expected_px.pop_front();
          check_field("hue", want.hue, out_hue);
          check_field("saturation", want.saturation, out_saturation);
          check_field("brightness", want.brightness, out_brightness);
          check_field("alpha_out", want.alpha, out_alpha_out);
        end
      end
      pending_px = expected_px.size();
    end
  end

endmodule

### tb/sv/tb_top.sv
// Testbench top: clock, reset, pixel stimulus with random idling and stalls, and the verdict.
`timescale 1ns / 1ps
module tb_top;
  import rhsv_pkg::*;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  logic [CW-1:0] in_red;
  logic [CW-1:0] in_green;
  logic [CW-1:0] in_blue;
  logic [CW-1:0] in_alpha_in;
  logic          out_valid;
  logic          out_stall;
  logic [HW-1:0] out_hue;
  logic [CW-1:0] out_saturation;
  logic [CW-1:0] out_brightness;
  logic [CW-1:0] out_alpha_out;
  int            fail_count;
  int            pending_px;
  bit            calm;  // no idling or stalls on either side while set

  rgb_to_hsv_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_alpha_in    (in_alpha_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness),
    .out_alpha_out  (out_alpha_out)
  );

  hsv_conv_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_alpha_in    (in_alpha_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness),
    .out_alpha_out  (out_alpha_out),
    .fail_count     (fail_count),
    .pending_px     (pending_px)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side stalls at random, with a chance of about 9 in 100
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = !calm && ($urandom_range(0, 99) < 9);
    end
  end

  // Run limit
  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Send one pixel, with an occasional idle cycle before it
  task automatic push_pixel(input logic [CW-1:0] r, input logic [CW-1:0] g,
                            input logic [CW-1:0] b, input logic [CW-1:0] a);
    if (!calm && $urandom_range(0, 99) < 9) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    in_red      = r;
    in_green    = g;
    in_blue     = b;
    in_alpha_in = a;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Hold off the sender until every result is back
  task automatic drain_pipeline();
    in_valid = 1'b0;
    while (pending_px != 0) @(negedge clk);
  endtask

  // Random pixel, weighted toward the sector edges and the special cases
  task automatic push_random_pixel();
    logic [CW-1:0] r, g, b, a, lvl;
    r   = CW'($urandom);
    g   = CW'($urandom);
    b   = CW'($urandom);
    a   = CW'($urandom);
    lvl = CW'($urandom);
    case ($urandom_range(0, 9))
      0: begin  // grey
        r = lvl;
        g = lvl;
        b = lvl;
      end
      1: begin  // two channels share the maximum
        case ($urandom_range(0, 2))
          0: begin r = lvl; g = lvl; b = CW'($urandom_range(0, lvl)); end
          1: begin g = lvl; b = lvl; r = CW'($urandom_range(0, lvl)); end
          default: begin r = lvl; b = lvl; g = CW'($urandom_range(0, lvl)); end
        endcase
      end
      2: begin  // red max, blue at or just above green: hue near a full turn
        r = CW'($urandom_range(128, 255));
        g = CW'($urandom_range(0, 60));
        b = g + CW'($urandom_range(0, 2));
      end
      3: begin  // small values
        r = CW'($urandom_range(0, 3));
        g = CW'($urandom_range(0, 3));
        b = CW'($urandom_range(0, 3));
      end
      default: ;
    endcase
    push_pixel(r, g, b, a);
  endtask

  initial begin
    calm        = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_red      = '0;
    in_green    = '0;
    in_blue     = '0;
    in_alpha_in = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: black, grey, white, primaries, tied maxima, hue wrap, extremes
    push_pixel(8'd0, 8'd0, 8'd0, 8'd0);
    push_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    push_pixel(8'd128, 8'd128, 8'd128, 8'd77);
    push_pixel(8'd1, 8'd1, 8'd1, 8'd170);
    push_pixel(8'd255, 8'd0, 8'd0, 8'd85);
    push_pixel(8'd0, 8'd255, 8'd0, 8'd255);
    push_pixel(8'd0, 8'd0, 8'd255, 8'd0);
    push_pixel(8'd255, 8'd255, 8'd0, 8'd1);
    push_pixel(8'd0, 8'd255, 8'd255, 8'd254);
    push_pixel(8'd255, 8'd0, 8'd255, 8'd128);
    push_pixel(8'd255, 8'd0, 8'd1, 8'd127);
    push_pixel(8'd255, 8'd1, 8'd2, 8'd64);
    push_pixel(8'd200, 8'd10, 8'd11, 8'd32);
    push_pixel(8'd1, 8'd0, 8'd0, 8'd16);
    push_pixel(8'd0, 8'd1, 8'd1, 8'd8);
    push_pixel(8'd0, 8'd0, 8'd1, 8'd4);
    push_pixel(8'd255, 8'd254, 8'd254, 8'd2);
    push_pixel(8'd2, 8'd1, 8'd0, 8'd3);
    push_pixel(8'd3, 8'd1, 8'd2, 8'd240);
    push_pixel(8'd170, 8'd85, 8'd255, 8'd15);
    push_pixel(8'd85, 8'd170, 8'd0, 8'd204);
    push_pixel(8'd254, 8'd255, 8'd253, 8'd51);
    drain_pipeline();

    // Random part, with a stretch of no idling or stalls in the middle
    for (int i = 0; i < 1900; i++) begin
      calm = (i >= 700 && i < 1100);
      if (i == 1300) begin
        drain_pipeline();
      end
      push_random_pixel();
    end
    calm = 1'b0;

    drain_pipeline();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending_px == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hdl/rhsv_pkg.sv
hdl/rhsv_prep.sv
hdl/rhsv_div_cell.sv
hdl/rgb_to_hsv_unit.sv
tb/sv/hsv_conv_checker.sv
tb/sv/tb_top.sv
